// File: rtl/char_lcd_nibble_sequencer_core_defines.svh
// Assertion macros shared by the character LCD nibble sequencer RTL.
// No dependencies; the top level includes this file.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CLNS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("clns assertion failed");
`define CLNS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("clns assertion failed");
`else
`define CLNS_ASSERT_SAME(lbl, ante, cons)
`define CLNS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/clns_pkg.sv
// Types, codes and the microcode table of the character LCD nibble sequencer.
// No dependencies; every other RTL file imports this package.
package clns_pkg;

   // Input actions.
   localparam logic [2:0] ACT_CHAR   = 3'd0;
   localparam logic [2:0] ACT_CMD    = 3'd1;
   localparam logic [2:0] ACT_CURSOR = 3'd2;
   localparam logic [2:0] ACT_CLEAR  = 3'd3;
   localparam logic [2:0] ACT_HOME   = 3'd4;

   // Register indexes.
   localparam logic [1:0] REG_LINES = 2'd0;
   localparam logic [1:0] REG_WRAP  = 2'd1;
   localparam logic [1:0] REG_BL    = 2'd2;

   localparam logic [2:0] RST_LINES = 3'd2;
   localparam logic [5:0] RST_WRAP  = 6'd16;
   localparam logic       RST_BL    = 1'b1;

   // LCD command bytes.
   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_HOME  = 8'h02;
   localparam logic [7:0] CMD_DDRAM = 8'h80;

   // Beat phases within one LCD byte: three beats per nibble.
   localparam logic [2:0] PH_EN_HI  = 3'd1;
   localparam logic [2:0] PH_LO_NIB = 3'd3;
   localparam logic [2:0] PH_EN_LO  = 3'd4;
   localparam logic [2:0] PH_LAST   = 3'd5;

   // Byte sources.
   localparam logic [2:0] SRC_VAL   = 3'd0;
   localparam logic [2:0] SRC_CLEAR = 3'd1;
   localparam logic [2:0] SRC_HOME  = 3'd2;
   localparam logic [2:0] SRC_POS   = 3'd3;
   localparam logic [2:0] SRC_WRAP  = 3'd4;

   // Cursor updates applied at the end of a step.
   localparam logic [2:0] UPD_NONE = 3'd0;
   localparam logic [2:0] UPD_INC  = 3'd1;
   localparam logic [2:0] UPD_POS  = 3'd2;
   localparam logic [2:0] UPD_WRAP = 3'd3;
   localparam logic [2:0] UPD_HOME = 3'd4;

   // Jump conditions.
   localparam logic [1:0] CND_NEVER  = 2'd0;
   localparam logic [1:0] CND_ALWAYS = 2'd1;
   localparam logic [1:0] CND_NOWRAP = 2'd2;
   localparam logic [1:0] CND_ROWNZ  = 2'd3;

   // Program addresses.
   localparam logic [3:0] PC_CHAR     = 4'd0;
   localparam logic [3:0] PC_WRTEST   = 4'd1;
   localparam logic [3:0] PC_WRPOS    = 4'd2;
   localparam logic [3:0] PC_WRCLEAR  = 4'd3;
   localparam logic [3:0] PC_HOME     = 4'd4;
   localparam logic [3:0] PC_CMD      = 4'd5;
   localparam logic [3:0] PC_CURSOR   = 4'd6;
   localparam logic [3:0] PC_CLEAR    = 4'd7;
   localparam logic [3:0] PC_HALT     = 4'd15;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] byte_value;
      logic [5:0] target_column;
      logic [1:0] target_row;
   } req_type;

   typedef struct packed {
      logic [7:0] expander_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] line_count;
      logic [5:0] wrap_column;
      logic       backlight_on;
   } cfg_type;

   typedef struct packed {
      logic       halt;
      logic       send;
      logic [2:0] src;
      logic       rs;
      logic [2:0] upd;
      logic [1:0] cond;
      logic [3:0] target;
   } ucode_type;

   typedef struct packed {
      logic       load;
      logic       commit;
      logic [2:0] src;
      logic [2:0] upd;
   } dp_ctl_type;

   typedef struct packed {
      logic       nowrap;
      logic       rownz;
      logic [7:0] cmd_byte;
   } dp_stat_type;

   function automatic ucode_type clns_rom(input logic [3:0] pc);
      ucode_type w;
      w = '{halt: 1'b1, send: 1'b0, src: SRC_VAL, rs: 1'b0, upd: UPD_NONE,
            cond: CND_NEVER, target: PC_HALT};
      case (pc)
         PC_CHAR: w = '{1'b0, 1'b1, SRC_VAL, 1'b1, UPD_INC, CND_NOWRAP, PC_HALT};
         // Decision step only: off row 0 a wrap clears and homes the display.
         PC_WRTEST: w = '{1'b0, 1'b0, SRC_VAL, 1'b0, UPD_NONE, CND_ROWNZ, PC_WRCLEAR};
         PC_WRPOS: w = '{1'b0, 1'b1, SRC_WRAP, 1'b0, UPD_WRAP, CND_ALWAYS, PC_HALT};
         PC_WRCLEAR: w = '{1'b0, 1'b1, SRC_CLEAR, 1'b0, UPD_NONE, CND_NEVER, PC_HALT};
         PC_HOME: w = '{1'b0, 1'b1, SRC_HOME, 1'b0, UPD_HOME, CND_ALWAYS, PC_HALT};
         PC_CMD: w = '{1'b0, 1'b1, SRC_VAL, 1'b0, UPD_NONE, CND_ALWAYS, PC_HALT};
         PC_CURSOR: w = '{1'b0, 1'b1, SRC_POS, 1'b0, UPD_POS, CND_ALWAYS, PC_HALT};
         PC_CLEAR: w = '{1'b0, 1'b1, SRC_CLEAR, 1'b0, UPD_NONE, CND_ALWAYS, PC_HALT};
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] clns_entry(input logic [2:0] action);
      logic [3:0] pc;
      case (action)
         ACT_CHAR:   pc = PC_CHAR;
         ACT_CMD:    pc = PC_CMD;
         ACT_CURSOR: pc = PC_CURSOR;
         ACT_CLEAR:  pc = PC_CLEAR;
         ACT_HOME:   pc = PC_HOME;
         default:    pc = PC_HALT;
      endcase
      return pc;
   endfunction

   function automatic logic [6:0] clns_row_base(input logic [1:0] row);
      logic [6:0] b;
      case (row)
         2'd0:    b = 7'h00;
         2'd1:    b = 7'h40;
         2'd2:    b = 7'h14;
         default: b = 7'h54;
      endcase
      return b;
   endfunction

   // A row at or past the line count sits on the last line; zero lines counts as one.
   function automatic logic [1:0] clns_clamp(input logic [1:0] row, input logic [2:0] lines);
      logic [2:0] n;
      logic [2:0] top;
      n   = (lines == 3'd0) ? 3'd1 : lines;
      top = n - 3'd1;
      return ({1'b0, row} >= n) ? top[1:0] : row;
   endfunction

endpackage

// File: rtl/char_lcd_nibble_sequencer_core.sv
// Top level of the character LCD nibble sequencer.
// Depends on clns_pkg, clns_csr, clns_datapath, clns_sequencer and the defines header.
`include "char_lcd_nibble_sequencer_core_defines.svh"

// Turns LCD operations (write char, raw command, set cursor, clear, home) into the
// expander byte stream for a 4-bit character LCD: each LCD byte goes out as six beats,
// high nibble first, each nibble as plain, enable set, enable cleared, with RS and the
// backlight bit merged in. The block keeps the cursor column and row and wraps written
// characters at the wrap column. While a step sends, one beat per cycle goes out from the
// result register unless the result side stalls; a written character that hits the wrap
// column also passes through a microcode decision step that sends no beat. Unused actions
// produce no beats and are taken without leaving idle. A new item is taken once the
// sequencer has issued the final beat of the previous one, even while that beat still
// waits in the result register.
module char_lcd_nibble_sequencer_core
   import clns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type     cfg;
   dp_ctl_type  dp_ctl;
   dp_stat_type dp_stat;

   clns_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   clns_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cfg         (cfg),
      .ctl         (dp_ctl),
      .stat        (dp_stat)
   );

   clns_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_payload.action),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .backlight_on (cfg.backlight_on),
      .stat         (dp_stat),
      .ctl          (dp_ctl)
   );

   // The final beat of an item always has the enable bit low.
   `CLNS_ASSERT_SAME(a_last_enable_low, rsp_valid && rsp_payload.last, !rsp_payload.expander_byte[2])
   // An accepted item with a program keeps the sequencer busy in the next cycle.
   `CLNS_ASSERT_NEXT(a_busy_after_start, req_valid && req_ready && req_payload.action <= ACT_HOME, !req_ready)
   // The enable pulse never lands on the RS-less bit 1.
   `CLNS_ASSERT_SAME(a_bit1_clear, rsp_valid, !rsp_payload.expander_byte[1])

endmodule

// File: rtl/clns_csr.sv
// Configuration registers of the LCD nibble sequencer behind an APB-style port.
// Depends on clns_pkg.
module clns_csr
   import clns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic [2:0] lines_ff, lines_in;
   logic [5:0] wrap_ff, wrap_in;
   logic       bl_ff, bl_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      lines_in = lines_ff;
      wrap_in  = wrap_ff;
      bl_in    = bl_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_LINES: lines_in = pwdata[2:0];
            REG_WRAP:  wrap_in  = pwdata[5:0];
            REG_BL:    bl_in    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff <= RST_LINES;
         wrap_ff  <= RST_WRAP;
         bl_ff    <= RST_BL;
      end else begin
         lines_ff <= lines_in;
         wrap_ff  <= wrap_in;
         bl_ff    <= bl_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_LINES: prdata = {29'd0, lines_ff};
         REG_WRAP:  prdata = {26'd0, wrap_ff};
         REG_BL:    prdata = {31'd0, bl_ff};
         default:   prdata = 32'd0;
      endcase
   end

   assign cfg = '{line_count: lines_ff, wrap_column: wrap_ff, backlight_on: bl_ff};

endmodule

// File: rtl/clns_datapath.sv
// Datapath of the LCD nibble sequencer: held request, cursor registers, LCD byte select.
// Depends on clns_pkg; driven by clns_sequencer.
module clns_datapath
   import clns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_payload,
   input  cfg_type     cfg,
   input  dp_ctl_type  ctl,
   output dp_stat_type stat
);

   req_type    hold_ff;
   logic [5:0] col_ff, col_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] pos_row;
   logic [1:0] wrap_row;
   logic [5:0] col_inc;
   logic [6:0] pos_addr;
   logic [7:0] cmd_byte;

   assign pos_row  = clns_clamp(hold_ff.target_row, cfg.line_count);
   assign wrap_row = clns_clamp(2'd1, cfg.line_count);
   assign pos_addr = {1'b0, hold_ff.target_column} + clns_row_base(pos_row);
   assign col_inc  = col_ff + 6'd1;

   always_comb begin
      case (ctl.src)
         SRC_VAL:   cmd_byte = hold_ff.byte_value;
         SRC_CLEAR: cmd_byte = CMD_CLEAR;
         SRC_HOME:  cmd_byte = CMD_HOME;
         SRC_POS:   cmd_byte = CMD_DDRAM | {1'b0, pos_addr};
         SRC_WRAP:  cmd_byte = CMD_DDRAM | {1'b0, clns_row_base(wrap_row)};
         default:   cmd_byte = 8'd0;
      endcase
   end

   assign stat = '{nowrap:   (col_inc != cfg.wrap_column),
                   rownz:    (row_ff != 2'd0),
                   cmd_byte: cmd_byte};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctl.commit) begin
         case (ctl.upd)
            UPD_INC:  col_in = col_inc;
            UPD_POS: begin
               col_in = hold_ff.target_column;
               row_in = pos_row;
            end
            UPD_WRAP: begin
               col_in = 6'd0;
               row_in = wrap_row;
            end
            UPD_HOME: begin
               col_in = 6'd0;
               row_in = 2'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 6'd0;
         row_ff <= 2'd0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         hold_ff <= req_payload;
      end
   end

endmodule

// File: rtl/clns_sequencer.sv
// Microcode sequencer: step counter, beat phase counter and the result register.
// Depends on clns_pkg; controls clns_datapath.
module clns_sequencer
   import clns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        backlight_on,
   input  dp_stat_type stat,
   output dp_ctl_type  ctl
);

   logic       run_ff, run_in;
   logic [3:0] pc_ff, pc_in;
   logic [2:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   ucode_type  word;
   ucode_type  next_word;
   ucode_type  entry_word;
   logic       cond_true;
   logic [3:0] next_pc;
   logic       next_halt;
   logic [3:0] entry_pc;
   logic       accept;
   logic       start;
   logic       out_free;
   logic       beat_go;
   logic       step_end;
   logic [3:0] nibble;
   logic       en_bit;

   assign word = clns_rom(pc_ff);

   always_comb begin
      case (word.cond)
         CND_NEVER:  cond_true = 1'b0;
         CND_ALWAYS: cond_true = 1'b1;
         CND_NOWRAP: cond_true = stat.nowrap;
         CND_ROWNZ:  cond_true = stat.rownz;
         default:    cond_true = 1'b0;
      endcase
   end

   assign next_pc    = cond_true ? word.target : pc_ff + 4'd1;
   assign next_word  = clns_rom(next_pc);
   assign next_halt  = next_word.halt;
   assign entry_pc   = clns_entry(req_action);
   assign entry_word = clns_rom(entry_pc);

   assign req_ready = !run_ff;
   assign accept    = req_valid && !run_ff;
   // Actions without a program are taken and dropped without leaving idle.
   assign start     = accept && !entry_word.halt;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign beat_go   = run_ff && word.send && out_free;
   assign step_end  = run_ff && (!word.send || (beat_go && phase_ff == PH_LAST));

   assign nibble = (phase_ff < PH_LO_NIB) ? stat.cmd_byte[7:4] : stat.cmd_byte[3:0];
   assign en_bit = (phase_ff == PH_EN_HI) || (phase_ff == PH_EN_LO);

   always_comb begin
      run_in       = run_ff;
      pc_in        = pc_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         pc_in  = entry_pc;
         run_in = start;
      end
      if (step_end) begin
         pc_in = next_pc;
         if (next_halt) begin
            run_in = 1'b0;
         end
      end
      if (beat_go) begin
         phase_in     = (phase_ff == PH_LAST) ? 3'd0 : phase_ff + 3'd1;
         rsp_valid_in = 1'b1;
         rsp_data_in.expander_byte = {nibble, backlight_on, en_bit, 1'b0, word.rs};
         rsp_data_in.last          = (phase_ff == PH_LAST) && next_halt;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         pc_ff        <= PC_HALT;
         phase_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         pc_ff        <= pc_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign ctl = '{load: accept, commit: step_end, src: word.src, upd: word.upd};

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for char_lcd_nibble_sequencer_core: LCD operations go in and
// each expander beat coming out is checked against a predictor kept in a scoreboard class.
// Depends on clns_pkg and the RTL of the block.
module tb_top;
   import clns_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int PHASE_ITEMS    = 65;
   localparam int HOLD_OFF_BEATS = 1200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int EN_BIT         = 2;

   // Expected expander beats and the cursor and register state that decides them.
   class expander_beat_board;
      logic [2:0] line_count;
      logic [5:0] wrap_column;
      logic       backlight_on;
      logic [5:0] cursor_column;
      logic [1:0] cursor_row;
      rsp_type    pending_beats[$];
      rsp_type    step_beats[$];
      int unsigned faults;

      function new();
         line_count    = RST_LINES;
         wrap_column   = RST_WRAP;
         backlight_on  = RST_BL;
         cursor_column = '0;
         cursor_row    = '0;
         faults        = 0;
      endfunction

      function void apply_setting(input logic [1:0] index, input logic [31:0] value);
         case (index)
            REG_LINES: line_count   = value[2:0];
            REG_WRAP:  wrap_column  = value[5:0];
            REG_BL:    backlight_on = value[0];
            default: ;
         endcase
      endfunction

      // One nibble is three beats: plain, enable high, enable low.
      function void push_nibble(input logic [3:0] nib, input logic rs);
         rsp_type b;
         b.expander_byte = {nib, backlight_on, 1'b0, 1'b0, rs};
         b.last = 1'b0;
         step_beats.push_back(b);
         b.expander_byte[EN_BIT] = 1'b1;
         step_beats.push_back(b);
         b.expander_byte[EN_BIT] = 1'b0;
         step_beats.push_back(b);
      endfunction

      function void push_lcd_byte(input logic [7:0] v, input logic rs);
         push_nibble(v[7:4], rs);
         push_nibble(v[3:0], rs);
      endfunction

      function logic [6:0] row_offset(input logic [1:0] row);
         logic [6:0] offs;
         case (row)
            2'd0:    offs = 7'h00;
            2'd1:    offs = 7'h40;
            2'd2:    offs = 7'h14;
            default: offs = 7'h54;
         endcase
         return offs;
      endfunction

      function void move_cursor(input logic [5:0] col, input logic [1:0] row);
         logic [2:0] lines;
         logic [6:0] addr;
         lines = (line_count == 3'd0) ? 3'd1 : line_count;
         if ({1'b0, row} >= lines) row = 2'(lines - 3'd1);
         // The DDRAM address wraps in seven bits; the command bit stays set.
         addr = {1'b0, col} + row_offset(row);
         push_lcd_byte(CMD_DDRAM | {1'b0, addr}, 1'b0);
         cursor_column = col;
         cursor_row    = row;
      endfunction

      function void go_home();
         push_lcd_byte(CMD_HOME, 1'b0);
         cursor_column = '0;
         cursor_row    = '0;
      endfunction

      function void take_request(input req_type r);
         step_beats.delete();
         case (r.action)
            ACT_CHAR: begin
               push_lcd_byte(r.byte_value, 1'b1);
               cursor_column = cursor_column + 6'd1;
               if (cursor_column == wrap_column) begin
                  if (cursor_row == 2'd0) begin
                     move_cursor(6'd0, 2'd1);
                  end else begin
                     push_lcd_byte(CMD_CLEAR, 1'b0);
                     go_home();
                  end
               end
            end
            ACT_CMD:    push_lcd_byte(r.byte_value, 1'b0);
            ACT_CURSOR: move_cursor(r.target_column, r.target_row);
            ACT_CLEAR:  push_lcd_byte(CMD_CLEAR, 1'b0);
            ACT_HOME:   go_home();
            default: ;
         endcase
         if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
         foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
      endfunction

      function void check_beat(input rsp_type got);
         rsp_type want;
         if (pending_beats.size() == 0) begin
            $error("unexpected beat: expander_byte %02h last %0b", got.expander_byte, got.last);
            faults++;
            return;
         end
         want = pending_beats.pop_front();
         if (got.expander_byte !== want.expander_byte) begin
            $error("expander_byte expected %02h actual %02h", want.expander_byte,
                   got.expander_byte);
            faults++;
         end
         if (got.last !== want.last) begin
            $error("last expected %0b actual %0b", want.last, got.last);
            faults++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   expander_beat_board board;
   int          beats_seen = 0;
   int          burst_left = 0;

   char_lcd_nibble_sequencer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.take_request(req_payload);
         if (rsp_valid && rsp_ready) begin
            board.check_beat(rsp_payload);
            beats_seen++;
         end
      end
   end

   function automatic req_type make_op(input logic [2:0] action, input logic [7:0] value,
                                       input logic [5:0] col, input logic [1:0] row);
      req_type r;
      r.action        = action;
      r.byte_value    = value;
      r.target_column = col;
      r.target_row    = row;
      return r;
   endfunction

   // Mostly characters so the wrap paths get exercised; cursor moves often land just
   // short of the wrap column.
   function automatic req_type random_op();
      req_type r;
      int      pick;
      r.byte_value    = 8'($urandom);
      r.target_column = 6'($urandom);
      r.target_row    = 2'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.action = ACT_CHAR;
      end else if (pick < 65) begin
         r.action = ACT_CMD;
      end else if (pick < 80) begin
         r.action = ACT_CURSOR;
         if ($urandom_range(0, 1) == 1)
            r.target_column = 6'(board.wrap_column - 6'($urandom_range(1, 4)));
      end else if (pick < 87) begin
         r.action = ACT_CLEAR;
      end else if (pick < 94) begin
         r.action = ACT_HOME;
      end else begin
         r.action = ACT_HOME + 3'($urandom_range(1, 3));
      end
      return r;
   endfunction

   task automatic issue(input req_type r);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // Waits until every expected beat is out, then lets an ignored item finish too.
   task automatic settle_block();
      @(posedge clock);
      while (board.pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.apply_setting(index, data);
      @(posedge clock);
   endtask

   // The receiver changes its stall pattern every stretch and holds off once for long.
   initial begin
      int  mode;
      int  stretch;
      bit  held_off;
      held_off = 1'b0;
      forever begin
         if (!held_off && beats_seen >= HOLD_OFF_BEATS) begin
            held_off = 1'b1;
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(5, 60);
         repeat (stretch) begin
            @(posedge clock);
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("char_lcd_nibble_sequencer_core: mismatch");
      $finish;
   end

   initial begin
      logic [2:0] lines_set [6] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2};
      logic [5:0] wrap_set  [6] = '{6'd1, 6'd40, 6'd63, 6'd0, 6'd8, 6'd16};
      logic       bl_set    [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      req_type    r;
      int         counted;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      issue(make_op(ACT_CHAR, 8'h00, 6'd0, 2'd0));
      issue(make_op(ACT_CHAR, 8'hFF, 6'd63, 2'd3));
      issue(make_op(ACT_CMD, 8'h00, 6'd0, 2'd0));
      issue(make_op(ACT_CMD, 8'hFF, 6'd63, 2'd3));
      issue(make_op(ACT_CLEAR, 8'h5A, 6'd21, 2'd2));
      issue(make_op(ACT_HOME, 8'hA5, 6'd42, 2'd1));
      // Row past the line count clamps, and the address reaches the top of its seven bits.
      issue(make_op(ACT_CURSOR, 8'h00, 6'd63, 2'd3));
      issue(make_op(ACT_CURSOR, 8'hFF, 6'd39, 2'd0));
      issue(make_op(ACT_CURSOR, 8'h00, 6'd0, 2'd2));
      issue(make_op(ACT_HOME + 3'd1, 8'hFF, 6'd63, 2'd3));
      issue(make_op(ACT_HOME + 3'd2, 8'h00, 6'd0, 2'd0));
      issue(make_op(ACT_HOME + 3'd3, 8'h3C, 6'd7, 2'd1));
      // Wrap from row 0 to row 1, then a wrap on row 1 clears and homes.
      issue(make_op(ACT_CURSOR, 8'h00, 6'd14, 2'd0));
      issue(make_op(ACT_CHAR, 8'h41, 6'd0, 2'd0));
      issue(make_op(ACT_CHAR, 8'h42, 6'd0, 2'd0));
      issue(make_op(ACT_CURSOR, 8'h00, 6'd15, 2'd1));
      issue(make_op(ACT_CHAR, 8'h43, 6'd0, 2'd0));
      issue(make_op(ACT_CHAR, 8'h7E, 6'd0, 2'd0));

      for (int p = 0; p < 6; p++) begin
         req_valid <= 1'b0;
         settle_block();
         write_csr(REG_LINES, 32'(lines_set[p]));
         write_csr(REG_WRAP, 32'(wrap_set[p]));
         write_csr(REG_BL, 32'(bl_set[p]));
         burst_left = 0;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            r = random_op();
            issue(r);
            if (r.action <= ACT_HOME) counted++;
         end
      end

      req_valid <= 1'b0;
      settle_block();
      if (board.faults == 0)
         $display("char_lcd_nibble_sequencer_core: match");
      else
         $display("char_lcd_nibble_sequencer_core: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/clns_pkg.sv
rtl/clns_csr.sv
rtl/clns_datapath.sv
rtl/clns_sequencer.sv
rtl/char_lcd_nibble_sequencer_core.sv
tb/tb_top.sv
